// ===== src/bpa_pkg.sv =====
// Shared constants, types and helper functions of the bitmap page allocator.
package bpa_pkg;

  localparam int MAP_BYTES      = 1024;
  localparam int RESERVED_PAGES = 4;
  localparam int TOTAL_PAGES    = MAP_BYTES * 8;
  localparam int ADDR_W         = $clog2(MAP_BYTES);
  localparam int PAGE_W         = 13;
  localparam int CMD_W          = 2;
  localparam int STATUS_W       = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 2'd2;

  localparam logic [PAGE_W-1:0] LAST_PAGE_RST =
    PAGE_W'((RESERVED_PAGES > 0) ? (RESERVED_PAGES - 1) : (TOTAL_PAGES - 1));

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } map_wr_t;

  // Mask of a page inside its byte; the lowest page sits in the MSB.
  function automatic logic [7:0] page_mask(input logic [2:0] idx);
    page_mask = 8'h80 >> idx;
  endfunction

  // Bitmap byte after reset: the reserved pages are set.
  function automatic logic [7:0] reset_byte(input logic [ADDR_W-1:0] addr);
    logic [7:0] b;
    b = 8'h00;
    for (int j = 0; j < 8; j++) begin
      if ({addr, 3'(j)} < PAGE_W'(RESERVED_PAGES)) begin
        b[7-j] = 1'b1;
      end
    end
    reset_byte = b;
  endfunction

  function automatic logic page_usable(input logic [PAGE_W:0] p);
    page_usable = (p >= (PAGE_W+1)'(RESERVED_PAGES)) && (p < (PAGE_W+1)'(TOTAL_PAGES));
  endfunction

endpackage

// ===== src/bpa_in_if.sv =====
// Command channel of the bitmap page allocator.
interface bpa_in_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output command, output page, input ready);
  modport sink   (input valid, input command, input page, output ready);
endinterface

// ===== src/bpa_out_if.sv =====
// Result channel of the bitmap page allocator.
interface bpa_out_if;
  import bpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [PAGE_W-1:0]   page_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output page_out, output status, input ready);
  modport sink   (input valid, input page_out, input status, output ready);
endinterface

// ===== src/bpa_map.sv =====
// Used-page bitmap memory with one write port and one registered read port.
module bpa_map (
  input  logic                         clk,
  input  bpa_pkg::map_wr_t             wr,
  input  logic                         rd_en,
  input  logic [bpa_pkg::ADDR_W-1:0]   rd_addr,
  output logic [7:0]                   rd_data
);
  import bpa_pkg::*;

  logic [7:0] mem [MAP_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bpa_scan_unit.sv =====
// Examines one bitmap byte for the first free page inside the search window.
module bpa_scan_unit (
  input  logic [7:0] byte_data,
  input  logic [2:0] start_idx,
  input  logic       first_visit,
  input  logic       last_visit,
  output logic       found,
  output logic [2:0] found_idx,
  output logic [7:0] alloc_byte
);
  import bpa_pkg::*;

  logic [7:0] cand;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      cand[j] = !byte_data[7-j]
                && (!first_visit || (3'(j) >= start_idx))
                && (!last_visit  || (3'(j) <  start_idx));
    end
  end

  always_comb begin
    found     = 1'b0;
    found_idx = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (cand[j]) begin
        found     = 1'b1;
        found_idx = 3'(j);
      end
    end
  end

  assign alloc_byte = byte_data | page_mask(found_idx);

endmodule

// ===== src/bitmap_page_allocator_unit.sv =====
// Next-fit bitmap page allocator: a sequencer that walks the bitmap one byte at a time.
//
// After reset the block runs a clearing pass over all MAP_BYTES (1024) bytes, writing the
// reset bitmap, and takes no item meanwhile. Each item is then handled alone. Free and
// mark go through accept, bitmap read and update. Free or mark of a reserved or
// out-of-range page, and the unused command, are answered from the accept state. Allocate
// accepts and then reads and examines one bitmap byte after another: one byte when the
// byte holding the search start has a free page at or after the start, and MAP_BYTES+1
// bytes when the map is full. Each byte is read from the single bitmap memory before it is
// examined. A new item is accepted as soon as the sequencer is idle and the output
// register is empty or being emptied.
module bitmap_page_allocator_unit (
  input  logic      clk,
  input  logic      rst_n,
  bpa_in_if.sink    in_ch,
  bpa_out_if.source out_ch
);
  import bpa_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EX   = 3'd3;

  localparam int VISIT_W = ADDR_W + 1;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [VISIT_W-1:0]  visit_r, visit_nxt;
  logic [PAGE_W-1:0]   last_page_r, last_page_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]   out_page_r, out_page_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic                in_fire;
  logic                out_fire;
  logic [PAGE_W:0]     start_sum;
  logic [PAGE_W-1:0]   start_page;
  logic                rd_en;
  logic [7:0]          rd_data;
  map_wr_t             wr;
  logic                first_visit;
  logic                last_visit;
  logic                found;
  logic [2:0]          found_idx;
  logic [7:0]          alloc_byte;

  assign in_ch.ready   = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign out_fire      = out_valid_r && out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.page_out = out_page_r;
  assign out_ch.status   = out_status_r;

  assign start_sum  = {1'b0, last_page_r} + (PAGE_W+1)'(1);
  assign start_page = page_usable(start_sum) ? start_sum[PAGE_W-1:0]
                                             : PAGE_W'(RESERVED_PAGES);

  assign first_visit = (visit_r == '0);
  assign last_visit  = (visit_r == VISIT_W'(MAP_BYTES));

  bpa_map u_map (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  bpa_scan_unit u_scan (
    .byte_data   (rd_data),
    .start_idx   (page_r[2:0]),
    .first_visit (first_visit),
    .last_visit  (last_visit),
    .found       (found),
    .found_idx   (found_idx),
    .alloc_byte  (alloc_byte)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    addr_nxt       = addr_r;
    visit_nxt      = visit_r;
    last_page_nxt  = last_page_r;
    out_valid_nxt  = out_valid_r && !out_fire;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    wr             = '{en: 1'b0, addr: addr_r, data: rd_data};

    unique case (state_r)
      S_CLR: begin
        wr = '{en: 1'b1, addr: clr_addr_r, data: reset_byte(clr_addr_r)};
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(MAP_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_ch.command;
          priority if (in_ch.command == CMD_ALLOC) begin
            page_nxt  = start_page;
            addr_nxt  = start_page[PAGE_W-1:3];
            visit_nxt = '0;
            state_nxt = S_RD;
          end else if (in_ch.command == CMD_FREE || in_ch.command == CMD_MARK) begin
            if (page_usable({1'b0, in_ch.page})) begin
              page_nxt  = in_ch.page;
              addr_nxt  = in_ch.page[PAGE_W-1:3];
              state_nxt = S_RD;
            end else begin
              out_valid_nxt  = 1'b1;
              out_page_nxt   = in_ch.page;
              out_status_nxt = ST_RESERVED;
            end
          end else begin
            out_valid_nxt  = 1'b1;
            out_page_nxt   = in_ch.page;
            out_status_nxt = ST_OK;
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        if (cmd_r == CMD_ALLOC) begin
          priority if (found) begin
            wr             = '{en: 1'b1, addr: addr_r, data: alloc_byte};
            last_page_nxt  = {addr_r, found_idx};
            out_valid_nxt  = 1'b1;
            out_page_nxt   = {addr_r, found_idx};
            out_status_nxt = ST_OK;
            state_nxt      = S_IDLE;
          end else if (last_visit) begin
            out_valid_nxt  = 1'b1;
            out_page_nxt   = '0;
            out_status_nxt = ST_FULL;
            state_nxt      = S_IDLE;
          end else begin
            addr_nxt  = (addr_r == ADDR_W'(MAP_BYTES - 1)) ? '0 : addr_r + ADDR_W'(1);
            visit_nxt = visit_r + VISIT_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          wr = '{en: 1'b1, addr: addr_r,
                 data: (cmd_r == CMD_FREE) ? (rd_data & ~page_mask(page_r[2:0]))
                                           : (rd_data |  page_mask(page_r[2:0]))};
          out_valid_nxt  = 1'b1;
          out_page_nxt   = page_r;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      last_page_r <= LAST_PAGE_RST;
      out_valid_r <= 1'b0;
      visit_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      last_page_r <= last_page_nxt;
      out_valid_r <= out_valid_nxt;
      visit_r     <= visit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    addr_r       <= addr_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r || state_r == S_RD))
    else $error("Accepted item neither produced a result nor started a bitmap read.");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_ch.ready)
    else $error("Item accepted during the clearing pass.");

  a_full_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (out_page_r == '0))
    else $error("Full status reported with a nonzero page.");

  a_visit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EX || state_r == S_RD) |-> (visit_r <= VISIT_W'(MAP_BYTES)))
    else $error("Allocation scan ran past one full lap of the bitmap.");

  a_alloc_not_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EX && cmd_r == CMD_ALLOC && found)
      |-> ({addr_r, found_idx} >= PAGE_W'(RESERVED_PAGES)))
    else $error("Allocation picked a reserved page.");
`endif

endmodule

// ===== tb/page_alloc_checker.sv =====
// Checker for the bitmap page allocator: predicts each result from accepted commands and compares.
module page_alloc_checker
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if           in_ch,
  bpa_out_if          out_ch,
  output int unsigned mismatch_count,
  output int unsigned pending_results
);

  typedef struct packed {
    logic [PAGE_W-1:0]   page_out;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  bit [TOTAL_PAGES-1:0] page_map;
  logic [PAGE_W-1:0]    last_alloc;
  alloc_result_t        expected_results[$];

  function automatic alloc_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [PAGE_W-1:0] pg);
    alloc_result_t r;
    int probe;
    r.page_out = pg;
    r.status   = ST_OK;
    if (cmd == CMD_ALLOC) begin
      r.page_out = '0;
      r.status   = ST_FULL;
      probe = int'(last_alloc) + 1;
      if (probe < RESERVED_PAGES || probe >= TOTAL_PAGES) begin
        probe = RESERVED_PAGES;
      end
      for (int n = 0; n < TOTAL_PAGES - RESERVED_PAGES; n++) begin
        if (!page_map[probe]) begin
          page_map[probe] = 1'b1;
          last_alloc      = PAGE_W'(probe);
          r.page_out      = PAGE_W'(probe);
          r.status        = ST_OK;
          break;
        end
        probe++;
        if (probe >= TOTAL_PAGES) begin
          probe = RESERVED_PAGES;
        end
      end
    end else if (cmd == CMD_FREE || cmd == CMD_MARK) begin
      if (int'(pg) < RESERVED_PAGES || int'(pg) >= TOTAL_PAGES) begin
        r.status = ST_RESERVED;
      end else begin
        page_map[pg] = (cmd == CMD_MARK);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      page_map = '0;
      for (int p = 0; p < RESERVED_PAGES; p++) begin
        page_map[p] = 1'b1;
      end
      last_alloc = LAST_PAGE_RST;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("unexpected result: page_out=%0d status=%0d",
                     out_ch.page_out, out_ch.status);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_ch.page_out !== want.page_out || out_ch.status !== want.status) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
              $display({"result mismatch: expected page_out=%0d status=%0d, ",
                        "got page_out=%0d status=%0d"},
                       want.page_out, want.status, out_ch.page_out, out_ch.status);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_command(in_ch.command, in_ch.page));
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

// ===== tb/bitmap_page_allocator_unit_tb.sv =====
// Testbench top for the bitmap page allocator: reset, stimulus, result backpressure, verdict.
module bitmap_page_allocator_unit_tb;
  import bpa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS    = 1280;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 4000000;
  localparam int LOW_WINDOW      = 1023;

  logic clk = 1'b0;
  logic rst_n;
  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned cycle_count = 0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  always #4 clk = ~clk;

  bpa_in_if  cmd_ch ();
  bpa_out_if res_ch ();

  bitmap_page_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch)
  );

  page_alloc_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (cmd_ch),
    .out_ch          (res_ch),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return PAGE_W'($urandom_range(LOW_WINDOW));
    if (roll < 80) return PAGE_W'($urandom_range(TOTAL_PAGES - 1));
    if (roll < 90) return PAGE_W'($urandom_range(7));
    return PAGE_W'(TOTAL_PAGES - 1 - $urandom_range(7));
  endfunction

  function automatic logic [PAGE_W-1:0] pick_usable_page();
    return PAGE_W'($urandom_range(TOTAL_PAGES - 1, RESERVED_PAGES));
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] pg);
    int unsigned gap;
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= cmd;
    cmd_ch.page    <= pg;
    do @(posedge clk); while (!cmd_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned roll;
    int unsigned span;
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        res_ch.ready <= 1'b0;
        span = HOLD_OFF_CYCLES;
      end else begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          res_ch.ready <= 1'b1;
          span = $urandom_range(1, 6);
        end else if (roll < 65) begin
          res_ch.ready <= 1'b1;
          span = $urandom_range(40, 150);
        end else if (roll < 92) begin
          res_ch.ready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          res_ch.ready <= 1'b0;
          span = $urandom_range(10, 40);
        end
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned roll;
    logic [CMD_W-1:0] cmd;
    rst_n          = 1'b0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.command = CMD_ALLOC;
    cmd_ch.page    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first searches, reserved pages, repeated free and mark, the unused command.
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, 13'h1FFF);
    send_item(CMD_FREE, 13'd0);
    send_item(CMD_MARK, 13'd3);
    send_item(CMD_FREE, 13'd8191);
    send_item(CMD_MARK, 13'd8191);
    send_item(CMD_MARK, 13'd8191);
    send_item(CMD_FREE, 13'd8191);
    send_item(CMD_FREE, 13'd5);
    send_item(CMD_FREE, 13'd5);
    send_item(CMD_UNUSED, 13'd8191);
    send_item(CMD_UNUSED, 13'd0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_MARK, 13'd7);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 13'd4);
    send_item(CMD_MARK, 13'd4);
    send_item(CMD_FREE, 13'd2);
    send_item(CMD_MARK, 13'd1);
    send_item(CMD_ALLOC, '0);
    wait_drained();

    // Random mix of commands; allocations climb through the low window that frees target.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == 20) begin
        hold_off_req = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 45) cmd = CMD_ALLOC;
      else if (roll < 70) cmd = CMD_FREE;
      else if (roll < 92) cmd = CMD_MARK;
      else cmd = CMD_UNUSED;
      send_item(cmd, pick_page());
      counted++;
    end
    wait_drained();

    // Free pages on both sides of the search point and allocate again.
    send_item(CMD_FREE, 13'd8191);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 13'd50);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_FREE, 13'd8190);
    send_item(CMD_FREE, 13'd6);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '0);
    send_item(CMD_ALLOC, '0);
    for (int k = 0; k < 20; k++) begin
      send_item(CMD_FREE, pick_usable_page());
      send_item(CMD_ALLOC, '0);
    end
    send_item(CMD_ALLOC, '0);
    wait_drained();
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bpa_pkg.sv
src/bpa_in_if.sv
src/bpa_out_if.sv
src/bpa_map.sv
src/bpa_scan_unit.sv
src/bitmap_page_allocator_unit.sv
tb/page_alloc_checker.sv
tb/bitmap_page_allocator_unit_tb.sv
